FILE: design/multiviewer_tile_layout_unit_assert.svh
// Assertion macros shared by the layout unit files
`ifndef MULTIVIEWER_TILE_LAYOUT_UNIT_ASSERT_SVH
`define MULTIVIEWER_TILE_LAYOUT_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define MTL_ASSERT_IMP(label, clk_i, rst_ni, cond, prop) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
		else $error("assertion failed");

// next-cycle implication
`define MTL_ASSERT_NEXT(label, clk_i, rst_ni, cond, prop) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
		else $error("assertion failed");

`endif

FILE: design/mtl_pkg.sv
package mtl_pkg;
	localparam int MaxParticipants = 16;
	localparam int CntW = 5;
	localparam int SlotW = 7;
	localparam logic [SlotW-1:0] SlotMax = 7'd127;
	localparam logic [13:0] CanvasMax = 14'd8192;
	localparam logic [2:0] StripTiles = 3'd4;

	localparam logic [1:0] RegCanvasW = 2'd0;
	localparam logic [1:0] RegCanvasH = 2'd1;
	localparam logic [1:0] RegMode = 2'd2;
	localparam logic [1:0] RegPrimary = 2'd3;

	typedef struct packed {
		logic start;
		logic [27:0] num;
		logic [13:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [27:0] quo;
	} div_rsp_t;

	// grid side ceil(sqrt(n)) for n in 1..MaxParticipants
	function automatic logic [3:0] grid_side(input logic [CntW-1:0] n);
		logic [3:0] r;
		r = 4'd1;
		for (int i = 1; i < 8; i++) begin
			if (5'(r) * 5'(r) < n && r < 4'd8) r = r + 4'd1;
		end
		return r;
	endfunction
endpackage

FILE: design/mtl_divider.sv
module mtl_divider (
	input logic clk,
	input logic arst_n,
	input mtl_pkg::div_req_t req,
	output mtl_pkg::div_rsp_t rsp
);
	import mtl_pkg::*;
	`include "multiviewer_tile_layout_unit_assert.svh"

	logic [27:0] quo_q;
	logic [13:0] rem_q;
	logic [13:0] den_q;
	logic [4:0] cnt_q;
	logic busy_q, done_q;
	logic [14:0] trial;
	logic [14:0] shifted;

	assign shifted = {rem_q, quo_q[27]};
	assign trial = shifted - {1'b0, den_q};

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd27;
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[14]) begin
				rem_q <= trial[13:0];
				quo_q <= {quo_q[26:0], 1'b1};
			end else begin
				rem_q <= shifted[13:0];
				quo_q <= {quo_q[26:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo = quo_q;

	`MTL_ASSERT_IMP(a_done_after_busy, clk, arst_n, done_q, !busy_q)
	`MTL_ASSERT_IMP(a_no_restart, clk, arst_n, busy_q, !req.start)
	`MTL_ASSERT_NEXT(a_start_busy, clk, arst_n, req.start, busy_q)
endmodule

FILE: design/multiviewer_tile_layout_unit.sv
// Work per item, from accept to result valid: three divisions for a grid tile, two for a grid
// item with no free slot, one for a lone, primary or strip tile, and none for a size error
// or a strip item past the fourth tile.
// One item at a time; the next item is taken the cycle after the result is loaded into
// the output register.
// Reset (arst_n low, asynchronous): canvas 1920x1080, tiled, primary 0, pass state cleared.
module multiviewer_tile_layout_unit (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_stall,
	input logic [31:0] participant_id,
	input logic [13:0] source_width,
	input logic [13:0] source_height,
	input logic [4:0] participant_count,
	input logic first_of_pass,
	output logic out_valid,
	input logic out_stall,
	output logic [12:0] dest_x,
	output logic [12:0] dest_y,
	output logic [13:0] dest_width,
	output logic [13:0] dest_height,
	output logic placed,
	output logic size_error
);
	import mtl_pkg::*;
	`include "multiviewer_tile_layout_unit_assert.svh"

	typedef enum logic [2:0] {
		ST_IDLE, ST_TW, ST_TH, ST_FIT, ST_DONE, ST_OUT
	} state_t;

	state_t state_q;
	logic [13:0] cw_q, ch_q;
	logic mode_q;
	logic [31:0] prim_q, eff_q;
	logic [SlotW-1:0] slot_q;
	logic [13:0] sw_q, sh_q;
	logic [3:0] rows_q;
	logic [14:0] rx_q, ry_q, rw_q, rh_q;
	logic [4:0] cnt_q;
	logic place_q, err_q, widefit_q;
	logic [12:0] ox_q, oy_q;
	logic [13:0] ow_q, oh_q;
	logic op_q, oe_q;
	div_req_t dreq;
	div_rsp_t drsp;

	mtl_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic wr;
	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_comb begin
		case (paddr[3:2])
			RegCanvasW: prdata = {18'd0, cw_q};
			RegCanvasH: prdata = {18'd0, ch_q};
			RegMode: prdata = {31'd0, mode_q};
			RegPrimary: prdata = prim_q;
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q <= 14'd1920;
			ch_q <= 14'd1080;
			mode_q <= 1'b0;
			prim_q <= '0;
		end else if (wr) begin
			case (paddr[3:2])
				RegCanvasW: cw_q <= pwdata[13:0];
				RegCanvasH: ch_q <= pwdata[13:0];
				RegMode: mode_q <= pwdata[0];
				RegPrimary: prim_q <= pwdata;
				default: ;
			endcase
		end
	end

	// clamped canvas
	logic [13:0] cw, ch;
	assign cw = (cw_q == 14'd0) ? 14'd1 : ((cw_q > CanvasMax) ? CanvasMax : cw_q);
	assign ch = (ch_q == 14'd0) ? 14'd1 : ((ch_q > CanvasMax) ? CanvasMax : ch_q);

	logic in_acc;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;

	// item decode at accept
	logic [31:0] eff_n, prim_n;
	logic [SlotW-1:0] slot_n;
	logic [4:0] cnt_n;
	logic err_n;
	always_comb begin
		eff_n = first_of_pass ? participant_id : eff_q;
		slot_n = first_of_pass ? '0 : slot_q;
		cnt_n = (participant_count == 5'd0) ? 5'd1 :
			((participant_count > 5'(MaxParticipants)) ? 5'(MaxParticipants) :
			participant_count);
		prim_n = (prim_q != 32'd0) ? prim_q : eff_n;
		err_n = (source_width == 14'd0) || (source_height == 14'd0);
	end

	logic [14:0] bigh;
	assign bigh = {3'd0, ch[13:2]} + {2'd0, ch[13:2], 1'b0};

	// fit compare: rw*sh > rh*sw
	logic [28:0] lhs, rhs;
	assign lhs = 29'(rw_q * sh_q);
	assign rhs = 29'(rh_q * sw_q);

	always_comb begin
		dreq.start = 1'b0;
		dreq.num = '0;
		dreq.den = 14'd1;
		case (state_q)
			ST_IDLE: if (in_acc && !err_n && cnt_n != 5'd1 && mode_q == 1'b0) begin
				dreq.start = 1'b1;
				dreq.num = {14'd0, cw};
				dreq.den = {10'd0, grid_side(cnt_n)};
			end
			ST_TW: if (drsp.done) begin
				dreq.start = 1'b1;
				dreq.num = {14'd0, ch};
				dreq.den = {10'd0, rows_q};
			end
			ST_FIT: begin
				dreq.start = 1'b1;
				if (lhs > rhs) begin
					dreq.num = 28'(sw_q * rh_q);
					dreq.den = sh_q;
				end else begin
					dreq.num = 28'(sh_q * rw_q);
					dreq.den = sw_q;
				end
			end
			default: ;
		endcase
	end

	logic [14:0] nq;
	assign nq = drsp.quo[14:0];

	// grid position of the slot held in rx
	logic [3:0] gcol, grow;
	always_comb begin
		gcol = '0;
		grow = '0;
		for (int i = 0; i < MaxParticipants; i++) begin
			if (rx_q >= 15'(i) * 15'(rows_q) && rx_q < 15'(MaxParticipants)) begin
				grow = 4'(i);
				gcol = 4'(rx_q[4:0] - 5'(5'(i) * 5'(rows_q)));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			eff_q <= '0;
			slot_q <= '0;
			sw_q <= '0;
			sh_q <= '0;
			cnt_q <= '0;
			err_q <= 1'b0;
			rows_q <= '0;
			rx_q <= '0;
			ry_q <= '0;
			rw_q <= '0;
			rh_q <= '0;
			place_q <= 1'b0;
			widefit_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_acc) begin
					eff_q <= eff_n;
					sw_q <= source_width;
					sh_q <= source_height;
					cnt_q <= cnt_n;
					err_q <= err_n;
					rows_q <= grid_side(cnt_n);
					rx_q <= '0;
					ry_q <= '0;
					rw_q <= '0;
					rh_q <= '0;
					place_q <= 1'b0;
					slot_q <= slot_n;
					if (cnt_n == 5'd1) begin
						rw_q <= {1'b0, cw};
						rh_q <= {1'b0, ch};
						place_q <= !err_n;
						if (slot_n < SlotMax) slot_q <= slot_n + 7'd1;
						state_q <= err_n ? ST_DONE : ST_FIT;
					end else if (mode_q == 1'b0) begin
						if (slot_n < SlotMax) slot_q <= slot_n + 7'd1;
						// hold pre-increment slot in rx for grid index
						rx_q <= {8'd0, slot_n};
						state_q <= err_n ? ST_DONE : ST_TW;
					end else if (participant_id == prim_n) begin
						rw_q <= {1'b0, cw};
						rh_q <= bigh;
						place_q <= !err_n;
						state_q <= err_n ? ST_DONE : ST_FIT;
					end else if (slot_n < 7'(StripTiles)) begin
						rx_q <= 15'(slot_n[1:0] * cw[13:2]);
						ry_q <= bigh;
						rw_q <= {3'd0, cw[13:2]};
						rh_q <= {3'd0, ch[13:2]};
						place_q <= !err_n;
						slot_q <= slot_n + 7'd1;
						state_q <= err_n ? ST_DONE : ST_FIT;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_TW: if (drsp.done) begin
					rw_q <= nq;
					slot_q <= slot_q;
					state_q <= ST_TH;
				end
				ST_TH: if (drsp.done) begin
					rh_q <= nq;
					if (rx_q < 15'(cnt_q)) begin
						place_q <= 1'b1;
						rx_q <= 15'(rw_q * gcol);
						ry_q <= 15'(nq * grow);
						state_q <= ST_FIT;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_FIT: begin
					widefit_q <= lhs > rhs;
					state_q <= ST_OUT;
				end
				ST_OUT: if (drsp.done) begin
					if (widefit_q) begin
						rx_q <= rx_q + ((rw_q - nq) >> 1);
						rw_q <= nq;
					end else begin
						ry_q <= ry_q + ((rh_q - nq) >> 1);
						rh_q <= nq;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: if (!out_valid || !out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	logic ov_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else begin
			if (ov_q && !out_stall) ov_q <= 1'b0;
			if (state_q == ST_DONE && (!ov_q || !out_stall)) ov_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!ov_q || !out_stall)) begin
			ox_q <= place_q ? rx_q[12:0] : 13'd0;
			oy_q <= place_q ? ry_q[12:0] : 13'd0;
			ow_q <= place_q ? rw_q[13:0] : 14'd0;
			oh_q <= place_q ? rh_q[13:0] : 14'd0;
			op_q <= place_q;
			oe_q <= err_q;
		end
	end

	assign out_valid = ov_q;
	assign dest_x = ox_q;
	assign dest_y = oy_q;
	assign dest_width = ow_q;
	assign dest_height = oh_q;
	assign placed = op_q;
	assign size_error = oe_q;

	`MTL_ASSERT_IMP(a_err_not_placed, clk, arst_n, out_valid && size_error, !placed)
	`MTL_ASSERT_IMP(a_busy_stalls, clk, arst_n, drsp.busy, in_stall)
	`MTL_ASSERT_NEXT(a_done_to_idle, clk, arst_n, state_q == ST_DONE && !out_stall,
		state_q == ST_IDLE)
endmodule

FILE: bench/multiviewer_tile_layout_unit_tb.sv
`timescale 1ns / 100ps

module multiviewer_tile_layout_unit_tb;
	import mtl_pkg::*;

	typedef struct {
		logic [31:0] id;
		logic [13:0] sw;
		logic [13:0] sh;
		logic [4:0] cnt;
		logic first;
	} layout_req_t;

	typedef struct {
		logic [12:0] x;
		logic [12:0] y;
		logic [13:0] w;
		logic [13:0] h;
		logic placed;
		logic err;
	} tile_rect_t;

	class placement_board;
		bit [13:0] cw_reg = 14'd1920;
		bit [13:0] ch_reg = 14'd1080;
		bit mode_reg;
		bit [31:0] prim_reg;
		bit [31:0] eff_prim;
		bit [6:0] slot_cnt;
		tile_rect_t pending[$];
		int errors;

		function void write_reg(logic [1:0] idx, logic [31:0] v);
			case (idx)
				RegCanvasW: cw_reg = v[13:0];
				RegCanvasH: ch_reg = v[13:0];
				RegMode: mode_reg = v[0];
				RegPrimary: prim_reg = v;
				default: ;
			endcase
		endfunction

		function void note_request(layout_req_t r);
			longint unsigned cw, ch, cnt, rx, ry, rw, rh, sw, sh, rows, tw, th, nw, nh;
			bit [31:0] prim;
			bit [6:0] slot;
			bit place, err;
			tile_rect_t e;
			rx = 0; ry = 0; rw = 0; rh = 0; place = 0;
			sw = r.sw; sh = r.sh;
			if (r.first) begin
				eff_prim = r.id;
				slot_cnt = 0;
			end
			cw = (cw_reg == 0) ? 1 : (cw_reg > 8192) ? 8192 : cw_reg;
			ch = (ch_reg == 0) ? 1 : (ch_reg > 8192) ? 8192 : ch_reg;
			cnt = (r.cnt == 0) ? 1 : (r.cnt > MaxParticipants) ? MaxParticipants : r.cnt;
			prim = (prim_reg != 0) ? prim_reg : eff_prim;
			slot = slot_cnt;
			if (cnt == 1) begin
				rw = cw; rh = ch; place = 1;
				if (slot_cnt < 127) slot_cnt++;
			end else if (!mode_reg) begin
				rows = 1;
				while (rows * rows < cnt) rows++;
				tw = cw / rows; th = ch / rows;
				if (slot < cnt) begin
					rx = (slot % rows) * tw;
					ry = (slot / rows) * th;
					rw = tw; rh = th; place = 1;
				end
				if (slot_cnt < 127) slot_cnt++;
			end else begin
				th = ch / 4;
				tw = cw / 4;
				if (r.id == prim) begin
					rw = cw; rh = th * 3; place = 1;
				end else if (slot < 4) begin
					rx = slot * tw; ry = th * 3;
					rw = tw; rh = th; place = 1;
					slot_cnt++;
				end
			end
			err = (sw == 0 || sh == 0);
			if (err) place = 0;
			if (place) begin
				if (rw * sh > rh * sw) begin
					nw = sw * rh / sh;
					rx += (rw - nw) / 2;
					rw = nw;
				end else begin
					nh = sh * rw / sw;
					ry += (rh - nh) / 2;
					rh = nh;
				end
			end else begin
				rx = 0; ry = 0; rw = 0; rh = 0;
			end
			e.x = rx[12:0]; e.y = ry[12:0]; e.w = rw[13:0]; e.h = rh[13:0];
			e.placed = place; e.err = err;
			pending = {pending, e};
		endfunction

		function void check_rect(tile_rect_t a);
			tile_rect_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result x=%0d y=%0d w=%0d h=%0d",
					a.x, a.y, a.w, a.h);
				return;
			end
			e = pending.pop_front();
			if (a.x !== e.x || a.y !== e.y || a.w !== e.w || a.h !== e.h ||
					a.placed !== e.placed || a.err !== e.err) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch exp x=%0d y=%0d w=%0d h=%0d p=%0b e=%0b,",
						" got x=%0d y=%0d w=%0d h=%0d p=%0b e=%0b"},
						e.x, e.y, e.w, e.h, e.placed, e.err,
						a.x, a.y, a.w, a.h, a.placed, a.err);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_stall;
	logic [31:0] participant_id = '0;
	logic [13:0] source_width = '0;
	logic [13:0] source_height = '0;
	logic [4:0] participant_count = '0;
	logic first_of_pass = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [12:0] dest_x, dest_y;
	logic [13:0] dest_width, dest_height;
	logic placed, size_error;

	placement_board board = new();
	int items_sent;
	int idle_cycles;

	multiviewer_tile_layout_unit dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_rect('{dest_x, dest_y, dest_width, dest_height, placed, size_error});
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver stall pattern, with one long hold-off mid-run
	int hold_left;
	bit hold_done;
	int stall_style;
	always @(posedge clk) begin
		if (!hold_done && items_sent >= 400) begin
			hold_done = 1;
			hold_left = 400;
		end
		if ($urandom_range(0, 63) == 0) stall_style = $urandom_range(0, 2);
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1;
		end else case (stall_style)
			0: out_stall <= 0;
			1: out_stall <= 1'($urandom_range(0, 1));
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		board.write_reg(idx, v);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic drain;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	// leaves valid high; caller lowers it for a gap
	task automatic send_item(layout_req_t r);
		in_valid <= 1;
		participant_id <= r.id;
		source_width <= r.sw;
		source_height <= r.sh;
		participant_count <= r.cnt;
		first_of_pass <= r.first;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_request(r);
		items_sent++;
	endtask

	int burst_left;
	task automatic pace;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		in_valid <= 0;
		repeat ($urandom_range(1, 12)) @(posedge clk);
		burst_left = $urandom_range(0, 20);
	endtask

	function automatic logic [13:0] pick_size();
		case ($urandom_range(0, 19))
			0: return 14'd0;
			1: return 14'($urandom_range(0, 16383));
			2: return 14'd8192;
			3: return 14'd1;
			default: return 14'($urandom_range(1, 4096));
		endcase
	endfunction

	task automatic run_pass();
		layout_req_t r;
		int n, extra, cnt;
		bit [31:0] id;
		n = $urandom_range(1, 16);
		cnt = n;
		extra = 0;
		case ($urandom_range(0, 9))
			0: extra = $urandom_range(1, 5);
			1: cnt = 0;
			2: cnt = $urandom_range(17, 31);
			3: cnt = $urandom_range(1, 16);
			default: ;
		endcase
		id = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 1000);
		for (int k = 0; k < n + extra; k++) begin
			r.id = id;
			if (board.prim_reg != 0 && $urandom_range(0, 5) == 0) r.id = board.prim_reg;
			r.sw = pick_size();
			r.sh = pick_size();
			r.cnt = 5'(cnt);
			r.first = (k == 0) || ($urandom_range(0, 60) == 0);
			send_item(r);
			pace();
			id = id + $urandom_range(1, 500);
		end
	endtask

	initial begin
		layout_req_t r;
		logic [31:0] cfg[4];
		repeat (11) @(posedge clk);
		arst_n <= 1;
		repeat (3) @(posedge clk);

		// items before any pass start, then a tiled overflow pass
		for (int k = 0; k < 12; k++) begin
			r.id = 32'hFFFF_FFF0 + k;
			r.sw = (k == 2) ? 14'd0 : (k == 3) ? 14'h3FFF : 14'd640;
			r.sh = (k == 4) ? 14'd0 : (k == 5) ? 14'h3FFF : 14'd480;
			r.cnt = (k < 2) ? 5'd0 : (k < 4) ? 5'd31 : 5'd4;
			r.first = (k == 6);
			send_item(r);
		end
		in_valid <= 0;
		drain();
		// one-big mode: absent primary, then more than four strip tiles
		reg_write(RegMode, 32'd1);
		reg_write(RegPrimary, 32'd77);
		for (int k = 0; k < 7; k++) begin
			r.id = 70 + 3 * k;
			r.sw = 14'd1280; r.sh = 14'd720;
			r.cnt = 5'd7;
			r.first = (k == 0);
			send_item(r);
		end
		in_valid <= 0;
		drain();
		reg_write(RegPrimary, 32'd0);
		for (int k = 0; k < 6; k++) begin
			r.id = 5 + k;
			r.sw = 14'(100 + k); r.sh = 14'd8192;
			r.cnt = 5'd6;
			r.first = (k == 0);
			send_item(r);
		end
		in_valid <= 0;
		drain();

		for (int ph = 0; ph < 13; ph++) begin
			case (ph % 5)
				0: begin cfg[0] = 0; cfg[1] = 0; end
				1: begin cfg[0] = 8192; cfg[1] = 8192; end
				2: begin cfg[0] = 32'h3FFF; cfg[1] = 32'h3FFF; end
				3: begin cfg[0] = 1; cfg[1] = $urandom_range(1, 8192); end
				default: begin cfg[0] = $urandom; cfg[1] = $urandom; end
			endcase
			cfg[2] = $urandom;
			case ($urandom_range(0, 3))
				0: cfg[3] = 0;
				1: cfg[3] = 32'hFFFF_FFFF;
				default: cfg[3] = $urandom_range(1, 3000);
			endcase
			reg_write(RegCanvasW, cfg[0]);
			reg_write(RegCanvasH, cfg[1]);
			reg_write(RegMode, cfg[2]);
			reg_write(RegPrimary, cfg[3]);
			burst_left = 0;
			repeat (8) begin
				run_pass();
				// sender waits for every result now and then
				if ($urandom_range(0, 5) == 0) begin
					in_valid <= 0;
					@(posedge clk);
					while (board.pending.size() != 0) @(posedge clk);
				end
			end
			in_valid <= 0;
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

FILE: files.f
+incdir+design
design/mtl_pkg.sv
design/mtl_divider.sv
design/multiviewer_tile_layout_unit.sv
bench/multiviewer_tile_layout_unit_tb.sv
